// ===== design/bsrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_pkg
// shared types and constants of the projected box screen rectangle block
// ----------------------------------------------------------------------------
package bsrp_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BOX  = 1'b1;

    localparam logic [1:0] REG_VP_X = 2'd0;
    localparam logic [1:0] REG_VP_Y = 2'd1;
    localparam logic [1:0] REG_VP_W = 2'd2;
    localparam logic [1:0] REG_VP_H = 2'd3;

    localparam logic [14:0] VP_SIZE_RESET = 15'd1024;

    typedef struct packed {
        logic               opcode;
        logic [4:0]         coeff_index;
        logic signed [31:0] coeff_value;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } req_t;

    typedef struct packed {
        logic signed [15:0] screen_min_x;
        logic signed [15:0] screen_min_y;
        logic signed [15:0] screen_max_x;
        logic signed [15:0] screen_max_y;
        logic               none_projected;
    } res_t;

    // control that travels with a corner through the pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tag_t;

endpackage
`default_nettype wire

// ===== design/bsrp_xform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_xform
// one 4x4 fixed-point matrix times vector, two stages: products, then sum
// ----------------------------------------------------------------------------
module bsrp_xform #(
    parameter int FRAC_BITS = bsrp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic [15:0][31:0]   mat,
    input  wire logic [3:0][31:0]    vec,
    output logic      [3:0][31:0]    res
);
    logic signed [63:0] prod_reg [16];
    logic        [3:0][31:0] res_reg;
    logic signed [65:0] acc [4];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 16; i++) begin
                prod_reg[i] <= ($signed(mat[i]) * $signed(vec[i % 4])) >>> FRAC_BITS;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            acc[r] = 66'(prod_reg[r*4]) + 66'(prod_reg[r*4+1])
                   + 66'(prod_reg[r*4+2]) + 66'(prod_reg[r*4+3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 4; r++) begin
                if (acc[r] > 66'sd2147483647) begin
                    res_reg[r] <= 32'h7fffffff;
                end else if (acc[r] < -66'sd2147483648) begin
                    res_reg[r] <= 32'h80000000;
                end else begin
                    res_reg[r] <= acc[r][31:0];
                end
            end
        end
    end

    assign res = res_reg;

    logic unused_rst;
    assign unused_rst = aresetn;
endmodule
`default_nettype wire

// ===== design/bsrp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsrp_div
// pipelined restoring floor divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bsrp_div #(
    parameter int NW = 66,
    parameter int DW = 33,
    parameter int TW = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic        [DW-1:0] den,
    input  wire logic        [TW-1:0] tag_in,
    output logic signed      [NW-1:0] quo,
    output logic             [TW-1:0] tag_out
);
    // numerator made non-negative by one's complement: floor(n/d) = ~(~n / d) for n<0
    logic [NW-1:0] q_reg   [NW+1];
    logic [DW:0]   r_reg   [NW+1];
    logic [DW-1:0] d_reg   [NW+1];
    logic          neg_reg [NW+1];
    logic [TW-1:0] t_reg   [NW+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]   <= num[NW-1] ? ~num : num;
            r_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= num[NW-1];
            for (int s = 0; s < NW; s++) begin
                logic [DW+1:0] trial;
                trial = {r_reg[s], q_reg[s][NW-1]};
                if (trial >= {2'b00, d_reg[s]}) begin
                    r_reg[s+1] <= (DW+1)'(trial - {2'b00, d_reg[s]});
                    q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b1};
                end else begin
                    r_reg[s+1] <= (DW+1)'(trial);
                    q_reg[s+1] <= {q_reg[s][NW-2:0], 1'b0};
                end
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    // tags are cleared so that no stale request leaves after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NW; s++) t_reg[s] <= '0;
        end else if (en) begin
            t_reg[0] <= tag_in;
            for (int s = 0; s < NW; s++) t_reg[s+1] <= t_reg[s];
        end
    end

    assign quo     = neg_reg[NW] ? ~q_reg[NW] : q_reg[NW];
    assign tag_out = t_reg[NW];
endmodule
`default_nettype wire

// ===== design/box_screen_rect_projection_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_screen_rect_projection_top
// screen rectangle of an axis-aligned box through modelview and projection
// ----------------------------------------------------------------------------
// order: corners issued in turn by the sequencer, then modelview transform,
// projection transform, scale register, divider, fold, result queue
// throughput: one corner per cycle; next box taken during the last corner if the
// result queue has room; a load waits until the last corner has read the projection matrix
// reset: viewport registers to origin 0 and size 1024, pipeline emptied;
// matrix store is not cleared
module box_screen_rect_projection_top #(
    parameter int FRAC_BITS = bsrp_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bsrp_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bsrp_pkg::res_t      m_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int NW   = 66;
    localparam int DW   = 33;
    localparam int DLAT = NW + 1;
    localparam int LAT  = 4 + 2 + DLAT + 1;
    // results that may be in flight: one per box
    localparam int FIFO_DEPTH = 16;

    logic [13:0] vp_x_reg, vp_y_reg;
    logic [14:0] vp_w_reg, vp_h_reg;
    logic [31:0] mem_reg [32];

    // apb
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_x_reg <= '0;
            vp_y_reg <= '0;
            vp_w_reg <= bsrp_pkg::VP_SIZE_RESET;
            vp_h_reg <= bsrp_pkg::VP_SIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                bsrp_pkg::REG_VP_X: vp_x_reg <= pwdata[13:0];
                bsrp_pkg::REG_VP_Y: vp_y_reg <= pwdata[13:0];
                bsrp_pkg::REG_VP_W: vp_w_reg <= pwdata[14:0];
                bsrp_pkg::REG_VP_H: vp_h_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            bsrp_pkg::REG_VP_X: prdata = {18'd0, vp_x_reg};
            bsrp_pkg::REG_VP_Y: prdata = {18'd0, vp_y_reg};
            bsrp_pkg::REG_VP_W: prdata = {17'd0, vp_w_reg};
            bsrp_pkg::REG_VP_H: prdata = {17'd0, vp_h_reg};
            default:            prdata = '0;
        endcase
    end

    // corner sequencer; a request is taken only while the result queue has room
    logic        busy_reg;
    logic [2:0]  corner_reg;
    bsrp_pkg::req_t box_reg;
    logic [4:0]  fifo_cnt_reg;
    logic [6:0]  inflight_reg;
    logic        en;
    logic        box_acc, load_acc, res_push, res_pop;
    logic        room, box_ok, load_ok;
    bsrp_pkg::tag_t tag_d [4];

    assign en       = 1'b1;
    assign room     = (32'(fifo_cnt_reg) + 32'(inflight_reg)) < FIFO_DEPTH;
    assign box_ok   = !busy_reg || corner_reg == 3'd7;
    // a load waits until the last corner has read the projection matrix
    assign load_ok  = !busy_reg && !tag_d[0].vld;
    assign s_ready  = room && ((s_data.opcode == bsrp_pkg::OP_BOX) ? box_ok : load_ok);
    assign box_acc  = s_valid && s_ready && (s_data.opcode == bsrp_pkg::OP_BOX);
    assign load_acc = s_valid && s_ready && (s_data.opcode == bsrp_pkg::OP_LOAD);

    always_ff @(posedge aclk) begin
        if (load_acc) begin
            mem_reg[s_data.coeff_index] <= s_data.coeff_value;
        end
        if (box_acc) begin
            box_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            corner_reg <= '0;
        end else if (box_acc) begin
            busy_reg   <= 1'b1;
            corner_reg <= '0;
        end else if (busy_reg) begin
            corner_reg <= corner_reg + 3'd1;
            if (corner_reg == 3'd7) begin
                busy_reg <= 1'b0;
            end
        end
    end

    logic [15:0][31:0] mv, pj;
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            mv[i] = mem_reg[i];
            pj[i] = mem_reg[i+16];
        end
    end

    logic [3:0][31:0] pnt, eye, clip;
    always_comb begin
        pnt[0] = corner_reg[2] ? box_reg.box_max_x : box_reg.box_min_x;
        pnt[1] = corner_reg[1] ? box_reg.box_max_y : box_reg.box_min_y;
        pnt[2] = corner_reg[0] ? box_reg.box_max_z : box_reg.box_min_z;
        pnt[3] = 32'(64'd1 << FRAC_BITS);
    end

    bsrp_xform #(.FRAC_BITS(FRAC_BITS)) u_mv (
        .aclk(aclk), .aresetn(aresetn), .en(en), .mat(mv), .vec(pnt), .res(eye));
    bsrp_xform #(.FRAC_BITS(FRAC_BITS)) u_pj (
        .aclk(aclk), .aresetn(aresetn), .en(en), .mat(pj), .vec(eye), .res(clip));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) tag_d[i] <= '0;
        end else begin
            tag_d[0] <= '{vld: busy_reg, first: corner_reg == 3'd0,
                          last: corner_reg == 3'd7};
            for (int i = 1; i < 4; i++) tag_d[i] <= tag_d[i-1];
        end
    end

    // numerators: c*s + w*s + w, denominator 2w, sign folded into numerator
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic        [DW-1:0] den_reg;
    logic                 wz_reg;
    bsrp_pkg::tag_t       t5_reg;
    logic signed [NW-1:0] nx, ny;
    logic signed [32:0]   w33;
    logic signed [47:0]   cxw, cww, cyh, cwh;
    always_comb begin
        w33 = 33'($signed(clip[3]));
        cxw = $signed(clip[0]) * $signed({1'b0, vp_w_reg});
        cww = $signed(clip[3]) * $signed({1'b0, vp_w_reg});
        cyh = $signed(clip[1]) * $signed({1'b0, vp_h_reg});
        cwh = $signed(clip[3]) * $signed({1'b0, vp_h_reg});
        nx  = NW'(cxw) + NW'(cww) + NW'(w33);
        ny  = NW'(cyh) + NW'(cwh) + NW'(w33);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t5_reg <= '0;
        end else begin
            t5_reg <= tag_d[3];
        end
        nx_reg  <= clip[3][31] ? -nx : nx;
        ny_reg  <= clip[3][31] ? -ny : ny;
        den_reg <= clip[3][31] ? DW'(-(w33 <<< 1)) : DW'(w33 <<< 1);
        wz_reg  <= (clip[3] == 32'd0);
    end

    localparam int TW = 4;
    logic signed [NW-1:0] qx, qy;
    logic [TW-1:0] tqx, tqy;
    logic [DW-1:0] den_safe;
    assign den_safe = wz_reg ? DW'(1) : den_reg;

    bsrp_div #(.NW(NW), .DW(DW), .TW(TW)) u_divx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .num(nx_reg), .den(den_safe),
        .tag_in({t5_reg.vld && !wz_reg, t5_reg.first, t5_reg.last, t5_reg.vld}),
        .quo(qx), .tag_out(tqx));
    bsrp_div #(.NW(NW), .DW(DW), .TW(TW)) u_divy (
        .aclk(aclk), .aresetn(aresetn), .en(en), .num(ny_reg), .den(den_safe),
        .tag_in(4'd0), .quo(qy), .tag_out(tqy));

    // fold into running bounds
    logic signed [NW:0] px, py;
    logic signed [NW:0] lox_reg, loy_reg, hix_reg, hiy_reg;
    logic               any_reg;
    logic               use_c, fst, lst, cv;
    logic signed [NW:0] lox_n, loy_n, hix_n, hiy_n;
    logic               any_n;
    assign px    = (NW+1)'(qx) + (NW+1)'($signed({1'b0, vp_x_reg}));
    assign py    = (NW+1)'(qy) + (NW+1)'($signed({1'b0, vp_y_reg}));
    assign use_c = tqx[3];
    assign fst   = tqx[2];
    assign lst   = tqx[1];
    assign cv    = tqx[0];
    always_comb begin
        lox_n = lox_reg; loy_n = loy_reg; hix_n = hix_reg; hiy_n = hiy_reg;
        any_n = fst ? 1'b0 : any_reg;
        if (use_c) begin
            if (!any_n || px < lox_n) lox_n = px;
            if (!any_n || px > hix_n) hix_n = px;
            if (!any_n || py < loy_n) loy_n = py;
            if (!any_n || py > hiy_n) hiy_n = py;
            any_n = 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (cv) begin
            lox_reg <= lox_n; loy_reg <= loy_n; hix_reg <= hix_n; hiy_reg <= hiy_n;
            any_reg <= any_n;
        end
    end
    logic fin_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) fin_reg <= 1'b0;
        else          fin_reg <= cv && lst;
    end

    function automatic logic [15:0] sat16(input logic signed [NW:0] v);
        if (v > (NW+1)'(32767)) return 16'h7fff;
        if (v < -(NW+1)'(32768)) return 16'h8000;
        return v[15:0];
    endfunction

    bsrp_pkg::res_t res;
    logic signed [NW:0] vx, vy, vxe, vye, a, b, c, d;
    always_comb begin
        vx  = (NW+1)'($signed({1'b0, vp_x_reg}));
        vy  = (NW+1)'($signed({1'b0, vp_y_reg}));
        vxe = vx + (NW+1)'($signed({1'b0, vp_w_reg}));
        vye = vy + (NW+1)'($signed({1'b0, vp_h_reg}));
        if (!any_reg) begin
            a = vx; b = vy; c = vx; d = vy;
        end else begin
            a = lox_reg < vx ? vx : lox_reg;
            b = loy_reg < vy ? vy : loy_reg;
            c = hix_reg > vxe ? vxe : hix_reg;
            d = hiy_reg > vye ? vye : hiy_reg;
        end
        res.screen_min_x   = sat16(a);
        res.screen_min_y   = sat16(b);
        res.screen_max_x   = sat16(c);
        res.screen_max_y   = sat16(d);
        res.none_projected = !any_reg;
    end

    // result queue
    bsrp_pkg::res_t fifo_mem [FIFO_DEPTH];
    logic [3:0] wp_reg, rp_reg;
    assign res_push = fin_reg;
    assign m_valid  = fifo_cnt_reg != 5'd0;
    assign res_pop  = m_valid && m_ready;
    assign m_data   = fifo_mem[rp_reg];
    always_ff @(posedge aclk) begin
        if (res_push) fifo_mem[wp_reg] <= res;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; fifo_cnt_reg <= '0; inflight_reg <= '0;
        end else begin
            if (res_push) wp_reg <= wp_reg + 4'd1;
            if (res_pop)  rp_reg <= rp_reg + 4'd1;
            fifo_cnt_reg <= fifo_cnt_reg + 5'(res_push) - 5'(res_pop);
            inflight_reg <= inflight_reg + 7'(box_acc) - 7'(res_push);
        end
    end

    logic [4:0] unused_bits;
    assign unused_bits = {tqy, 1'(LAT)};

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= 5'(FIFO_DEPTH)) else $error("result queue overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (fifo_cnt_reg < 5'(FIFO_DEPTH) || res_pop))
        else $error("push into full queue");
    a_busy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        box_acc |=> busy_reg && corner_reg == 3'd0) else $error("corner start");
endmodule
`default_nettype wire
